>>> sv/usc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usc_pkg
// Shared types, constants and helper functions for the salted SHA-1 checker.
// ----------------------------------------------------------------------------
package usc_pkg;

  localparam int unsigned MaxPassCharsDefault = 32;
  localparam int unsigned UseridChars         = 10;
  localparam int unsigned RoundsPerBlock      = 80;
  localparam int unsigned CfgIdxWidth         = 3;
  localparam int unsigned CfgDataWidth        = 64;
  localparam int unsigned PassLenWidth        = 6;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgUseridHigh = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgUseridLow  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgTarget0    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgTarget1    = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgTarget2    = 3'd4;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [4:0][31:0] ShaIv = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                        32'hEFCDAB89, 32'h67452301};

  typedef logic [15:0][31:0] blk_words_t;

  // one pipeline slot; v[0] is a ... v[4] is e
  typedef struct packed {
    logic             vld;
    logic             two;
    logic [4:0][31:0] v;
    blk_words_t       win;
    blk_words_t       nxt;
    logic [4:0][31:0] h;
  } usc_stage_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

`default_nettype wire

>>> sv/usc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usc_if
// Channel interfaces: password request, digest result, configuration write.
// ----------------------------------------------------------------------------
interface usc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] pass_chunk0;
  logic [63:0] pass_chunk1;
  logic [63:0] pass_chunk2;
  logic [63:0] pass_chunk3;
  logic [5:0]  pass_length;
  modport source (output valid, pass_chunk0, pass_chunk1, pass_chunk2, pass_chunk3,
                  pass_length, input ready);
  modport sink (input valid, pass_chunk0, pass_chunk1, pass_chunk2, pass_chunk3,
                pass_length, output ready);
endinterface

interface usc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word0;
  logic [63:0] digest_word1;
  logic [31:0] digest_word2;
  logic        matched;
  modport source (output valid, digest_word0, digest_word1, digest_word2, matched,
                  input ready);
  modport sink (input valid, digest_word0, digest_word1, digest_word2, matched,
                output ready);
endinterface

interface usc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/usc_msg_build.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usc_msg_build
// Lays out widened user id, widened password, padding and bit length
// into two 512-bit message blocks.
// ----------------------------------------------------------------------------
module usc_msg_build import usc_pkg::*; #(
  parameter int unsigned MAX_PASS_CHARS = MaxPassCharsDefault
) (
  input  wire logic [63:0]             uid_high_i,
  input  wire logic [15:0]             uid_low_i,
  input  wire logic [3:0][63:0]        chunks_i,
  input  wire logic [PassLenWidth-1:0] pass_length_i,
  output      blk_words_t              blk1_o,
  output      blk_words_t              blk2_o,
  output      logic                    two_o
);

  localparam logic [PassLenWidth-1:0] MaxLen = PassLenWidth'(MAX_PASS_CHARS);

  logic [PassLenWidth-1:0] len;
  logic [7:0]              total;
  logic [63:0]             bitlen;
  logic [31:0][7:0]        pb;
  logic [127:0][7:0]       mb;

  always_comb begin
    len    = (pass_length_i > MaxLen) ? MaxLen : pass_length_i;
    total  = 8'(UseridChars * 2) + {1'b0, len, 1'b0};
    two_o  = (total > 8'd55);
    bitlen = {53'd0, total, 3'd0};
    for (int i = 0; i < 32; i++) begin
      pb[i] = chunks_i[i / 8][63 - 8 * (i % 8) -: 8];
    end
    for (int p = 0; p < 128; p++) begin
      mb[p] = 8'h00;
      if (p < 20) begin
        if (p % 2 == 1) begin
          if (p / 2 < 8) mb[p] = uid_high_i[63 - 8 * (p / 2) -: 8];
          else           mb[p] = uid_low_i[15 - 8 * (p / 2 - 8) -: 8];
        end
      end else if (8'(p) < total) begin
        if (p % 2 == 1 && (p - 20) / 2 < 32) mb[p] = pb[5'((p - 20) / 2)];
      end else if (8'(p) == total) begin
        mb[p] = 8'h80;
      end else if (two_o && p >= 120) begin
        mb[p] = bitlen[8 * (127 - p) +: 8];
      end else if (!two_o && p >= 56 && p < 64) begin
        mb[p] = bitlen[8 * ((63 - p) % 8) +: 8];
      end
    end
    for (int j = 0; j < 16; j++) begin
      blk1_o[j] = {mb[4 * j], mb[4 * j + 1], mb[4 * j + 2], mb[4 * j + 3]};
      blk2_o[j] = {mb[64 + 4 * j], mb[65 + 4 * j], mb[66 + 4 * j], mb[67 + 4 * j]};
    end
  end

endmodule

`default_nettype wire

>>> sv/usc_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usc_round
// One registered SHA-1 round with its rolling 16-word schedule window.
// ----------------------------------------------------------------------------
module usc_round import usc_pkg::*; #(
  parameter int unsigned RND = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  usc_stage_t stage_i,
  output usc_stage_t stage_o
);

  logic [31:0] f, k, t, wn;
  usc_stage_t  nxt;

  always_comb begin
    if (RND < 20) begin
      f = (stage_i.v[1] & stage_i.v[2]) | (~stage_i.v[1] & stage_i.v[3]);
      k = K0;
    end else if (RND < 40) begin
      f = stage_i.v[1] ^ stage_i.v[2] ^ stage_i.v[3];
      k = K1;
    end else if (RND < 60) begin
      f = (stage_i.v[1] & stage_i.v[2]) | (stage_i.v[1] & stage_i.v[3]) |
          (stage_i.v[2] & stage_i.v[3]);
      k = K2;
    end else begin
      f = stage_i.v[1] ^ stage_i.v[2] ^ stage_i.v[3];
      k = K3;
    end
    t  = rotl(stage_i.v[0], 5) + f + stage_i.v[4] + k + stage_i.win[0];
    wn = rotl(stage_i.win[13] ^ stage_i.win[8] ^ stage_i.win[2] ^ stage_i.win[0], 1);
    nxt      = stage_i;
    nxt.v[0] = t;
    nxt.v[1] = stage_i.v[0];
    nxt.v[2] = rotl(stage_i.v[1], 30);
    nxt.v[3] = stage_i.v[2];
    nxt.v[4] = stage_i.v[3];
    for (int i = 0; i < 15; i++) nxt.win[i] = stage_i.win[i + 1];
    nxt.win[15] = wn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_o.vld <= 1'b0;
    end else if (en_i) begin
      stage_o <= nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/userid_salted_sha1_checker_unit.sv
`default_nettype none
// Pipeline: message register, 80 rounds, chaining add, 80 rounds, output
// register, as an unrolled round chain. Throughput: one request per cycle; a
// stalled result freezes the whole pipeline. Reset clears all valid bits and
// the configuration registers.
// ----------------------------------------------------------------------------
// userid_salted_sha1_checker_unit
// Fully unrolled two-block SHA-1 over widened user id plus password, with
// digest compare against a configured target.
// ----------------------------------------------------------------------------
module userid_salted_sha1_checker_unit import usc_pkg::*; #(
  parameter int unsigned MAX_PASS_CHARS = MaxPassCharsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  usc_in_if.sink    req_i,
  usc_out_if.source rsp_o,
  usc_cfg_if.sink   cfg_i
);

  logic [63:0] uid_high_q, tgt0_q, tgt1_q;
  logic [15:0] uid_low_q;
  logic [31:0] tgt2_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uid_high_q <= '0;
      uid_low_q  <= '0;
      tgt0_q     <= '0;
      tgt1_q     <= '0;
      tgt2_q     <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgUseridHigh: uid_high_q <= cfg_i.data;
        CfgUseridLow:  uid_low_q  <= cfg_i.data[15:0];
        CfgTarget0:    tgt0_q     <= cfg_i.data;
        CfgTarget1:    tgt1_q     <= cfg_i.data;
        CfgTarget2:    tgt2_q     <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  // message build
  blk_words_t blk1, blk2;
  logic       two;

  usc_msg_build #(.MAX_PASS_CHARS(MAX_PASS_CHARS)) u_build (
    .uid_high_i    (uid_high_q),
    .uid_low_i     (uid_low_q),
    .chunks_i      ({req_i.pass_chunk3, req_i.pass_chunk2, req_i.pass_chunk1,
                     req_i.pass_chunk0}),
    .pass_length_i (req_i.pass_length),
    .blk1_o        (blk1),
    .blk2_o        (blk2),
    .two_o         (two)
  );

  localparam int unsigned NStages = 2 * RoundsPerBlock + 2;

  usc_stage_t st [NStages];
  usc_stage_t in_q;
  usc_stage_t fold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q.vld <= 1'b0;
    end else if (en) begin
      in_q.vld <= req_i.valid;
      in_q.two <= two;
      in_q.v   <= ShaIv;
      in_q.win <= blk1;
      in_q.nxt <= blk2;
      in_q.h   <= ShaIv;
    end
  end

  assign st[0] = in_q;

  for (genvar r = 0; r < RoundsPerBlock; r++) begin : g_blk1
    usc_round #(.RND(r)) u_round (
      .clk_i, .rst_ni, .en_i(en), .stage_i(st[r]), .stage_o(st[r + 1])
    );
  end

  // chaining add between the blocks; second block words move into the window
  localparam int unsigned FoldIn = RoundsPerBlock;
  logic [4:0][31:0] h1;

  always_comb begin
    for (int i = 0; i < 5; i++) h1[i] = st[FoldIn].h[i] + st[FoldIn].v[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q.vld <= 1'b0;
    end else if (en) begin
      fold_q.vld <= st[FoldIn].vld;
      fold_q.two <= st[FoldIn].two;
      fold_q.v   <= h1;
      fold_q.win <= st[FoldIn].nxt;
      fold_q.nxt <= st[FoldIn].nxt;
      fold_q.h   <= h1;
    end
  end

  assign st[FoldIn + 1] = fold_q;

  for (genvar r = 0; r < RoundsPerBlock; r++) begin : g_blk2
    usc_round #(.RND(r)) u_round (
      .clk_i, .rst_ni, .en_i(en), .stage_i(st[FoldIn + 1 + r]),
      .stage_o(st[FoldIn + 2 + r])
    );
  end

  // final digest: one-block messages keep the chaining value from the add stage
  localparam int unsigned Last = NStages - 1;
  logic [4:0][31:0] dg;
  logic [63:0]      d0, d1;
  logic [31:0]      d2;
  logic [63:0]      d0_q, d1_q;
  logic [31:0]      d2_q;
  logic             match_q;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      dg[i] = st[Last].two ? (st[Last].h[i] + st[Last].v[i]) : st[Last].h[i];
    end
    d0 = {dg[0], dg[1]};
    d1 = {dg[2], dg[3]};
    d2 = dg[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= st[Last].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q    <= d0;
      d1_q    <= d1;
      d2_q    <= d2;
      match_q <= (d0 == tgt0_q) && (d1 == tgt1_q) && (d2 == tgt2_q);
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.digest_word0 = d0_q;
  assign rsp_o.digest_word1 = d1_q;
  assign rsp_o.digest_word2 = d2_q;
  assign rsp_o.matched      = match_q;

endmodule

`default_nettype wire
